// ----- rtl/core/rbg_pkg.sv -----
// Shared types and constants for the rotary and button gesture decoder.
// Depends on nothing; every other file in rtl/core imports it.
package rbg_pkg;

    // Event codes carried on the result word.
    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_CW     = 3'd1,
        EV_CCW    = 3'd2,
        EV_CLICK  = 3'd3,
        EV_DOUBLE = 3'd4,
        EV_HOLD3  = 3'd5,
        EV_HOLD5  = 3'd6
    } t_event;

    // Button machine phases, one-hot.
    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_PRESSED = 4'b0010,
        PH_WAITDBL = 4'b0100,
        PH_WAITREL = 4'b1000
    } t_phase;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_DEBOUNCE   = 3'd0,
        CFG_HOLD_SHORT = 3'd1,
        CFG_HOLD_LONG  = 3'd2,
        CFG_DBL_WINDOW = 3'd3,
        CFG_STALE      = 3'd4,
        CFG_THROTTLE   = 3'd5
    } t_cfg_idx;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned POS_W = 32;

    // Reset values of the configuration registers.
    localparam logic [15:0] DEBOUNCE_RST   = 16'd20;
    localparam logic [15:0] HOLD_SHORT_RST = 16'd3000;
    localparam logic [15:0] HOLD_LONG_RST  = 16'd5000;
    localparam logic [15:0] DBL_WINDOW_RST = 16'd300;
    localparam logic [7:0]  STALE_RST      = 8'd3;
    localparam logic [7:0]  THROTTLE_RST   = 8'd30;

    // Current configuration as seen by the datapath units.
    typedef struct packed {
        logic [15:0] quiet_ms;
        logic [15:0] hold_short_ms;
        logic [15:0] hold_long_ms;
        logic [15:0] double_window_ms;
        logic [7:0]  stale_ms;
        logic [7:0]  throttle_ms;
    } t_cfg;

endpackage

// ----- rtl/core/rbg_button.sv -----
// Button machine: press, hold, click and double-click detection with a
// one-word-deep queued event. Depends on rbg_pkg.
module rbg_button
    import rbg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [TIME_W-1:0]  i_now,
    input  logic               i_pressed,
    input  t_cfg               i_cfg,
    output t_event             o_queued
);

    t_phase              r_phase, n_phase;
    logic [TIME_W-1:0]   r_press_time, n_press_time;
    logic [TIME_W-1:0]   r_release_time, n_release_time;
    logic                r_hold_reported, n_hold_reported;
    t_event              r_queued, n_queued;

    logic [TIME_W-1:0]   w_held;
    logic [TIME_W-1:0]   w_since_release;
    logic                w_debounced;
    logic                w_ge_long;
    logic                w_ge_short;

    assign w_held          = i_now - r_press_time;
    assign w_since_release = i_now - r_release_time;
    assign w_debounced = w_since_release >= {16'd0, i_cfg.quiet_ms};
    assign w_ge_long   = w_held >= {16'd0, i_cfg.hold_long_ms};
    assign w_ge_short  = w_held >= {16'd0, i_cfg.hold_short_ms};

    // Next state. A pending event is delivered this word and the machine pauses.
    always_comb begin
        n_phase         = r_phase;
        n_press_time    = r_press_time;
        n_release_time  = r_release_time;
        n_hold_reported = r_hold_reported;
        n_queued        = r_queued;
        if (r_queued != EV_NONE) begin
            n_queued = EV_NONE;
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_pressed && w_debounced) begin
                        n_phase         = PH_PRESSED;
                        n_press_time    = i_now;
                        n_hold_reported = 1'b0;
                    end
                end
                PH_PRESSED: begin
                    if (!i_pressed) begin
                        if (w_ge_long) begin
                            n_phase = PH_IDLE;
                        end else if (w_ge_short) begin
                            if (!r_hold_reported) begin
                                n_queued        = EV_HOLD3;
                                n_hold_reported = 1'b1;
                            end
                            n_phase = PH_IDLE;
                        end else begin
                            n_phase        = PH_WAITDBL;
                            n_release_time = i_now;
                        end
                    end else if (!r_hold_reported && w_ge_long) begin
                        n_queued        = EV_HOLD5;
                        n_hold_reported = 1'b1;
                    end else if (!r_hold_reported && w_ge_short) begin
                        n_queued        = EV_HOLD3;
                        n_hold_reported = 1'b1;
                    end
                end
                PH_WAITDBL: begin
                    if (i_pressed && w_debounced) begin
                        n_queued = EV_DOUBLE;
                        n_phase  = PH_WAITREL;
                    end else if (w_since_release >= {16'd0, i_cfg.double_window_ms}) begin
                        n_queued = EV_CLICK;
                        n_phase  = PH_IDLE;
                    end
                end
                PH_WAITREL: begin
                    if (!i_pressed) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // State registers, advanced once per processed word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_press_time    <= '0;
            r_release_time  <= '0;
            r_hold_reported <= 1'b0;
            r_queued        <= EV_NONE;
        end else if (i_step) begin
            r_phase         <= n_phase;
            r_press_time    <= n_press_time;
            r_release_time  <= n_release_time;
            r_hold_reported <= n_hold_reported;
            r_queued        <= n_queued;
        end
    end

    assign o_queued = r_queued;

    // A pending event is gone after the word that delivers it.
    a_queue_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_queued != EV_NONE) |=> r_queued == EV_NONE)
        else $error("queued button event not cleared on delivery");

    // The machine does not move on the word that delivers an event.
    a_phase_paused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_queued != EV_NONE) |=> $stable(r_phase))
        else $error("button phase moved while delivering an event");

    // Only button gestures are ever queued.
    a_queue_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_queued != EV_CW && r_queued != EV_CCW)
        else $error("rotation code in button queue");

endmodule

// ----- rtl/core/rbg_rotary.sv -----
// Rotation backlog with stale drop and throttled emission; also picks the
// result code for each word. Depends on rbg_pkg.
module rbg_rotary
    import rbg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [TIME_W-1:0]  i_now,
    input  logic [POS_W-1:0]   i_pos,
    input  t_event             i_queued,
    input  t_cfg               i_cfg,
    output t_event             o_code
);

    logic [POS_W-1:0]   r_last_pos, n_last_pos;
    logic [POS_W-1:0]   r_backlog, n_backlog;
    logic [TIME_W-1:0]  r_move_time, n_move_time;
    logic [TIME_W-1:0]  r_event_time, n_event_time;

    logic [POS_W-1:0]   w_diff;
    logic [POS_W:0]     w_sum;
    logic [POS_W-1:0]   w_sat;
    logic [TIME_W-1:0]  w_move_age;
    logic [TIME_W-1:0]  w_event_age;

    // Saturating add of the position step to the backlog.
    assign w_diff = i_pos - r_last_pos;
    assign w_sum  = {r_backlog[POS_W-1], r_backlog} + {w_diff[POS_W-1], w_diff};
    assign w_sat  = (w_sum[POS_W] != w_sum[POS_W-1])
                  ? {w_sum[POS_W], {(POS_W-1){~w_sum[POS_W]}}}
                  : w_sum[POS_W-1:0];

    assign w_move_age  = i_now - r_move_time;
    assign w_event_age = i_now - r_event_time;

    // Backlog update, then either the queued button event or one rotation step.
    always_comb begin
        n_last_pos   = r_last_pos;
        n_backlog    = r_backlog;
        n_move_time  = r_move_time;
        n_event_time = r_event_time;
        o_code       = EV_NONE;
        if (i_pos != r_last_pos) begin
            n_backlog   = w_sat;
            n_last_pos  = i_pos;
            n_move_time = i_now;
        end else if (r_backlog != '0 && w_move_age > {24'd0, i_cfg.stale_ms}) begin
            n_backlog = '0;
        end
        if (i_queued != EV_NONE) begin
            o_code       = i_queued;
            n_backlog    = '0;
            n_event_time = i_now;
        end else if (w_event_age >= {24'd0, i_cfg.throttle_ms}) begin
            if (n_backlog[POS_W-1]) begin
                o_code       = EV_CCW;
                n_backlog    = n_backlog + 32'd1;
                n_event_time = i_now;
            end else if (n_backlog != '0) begin
                o_code       = EV_CW;
                n_backlog    = n_backlog - 32'd1;
                n_event_time = i_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_pos   <= '0;
            r_backlog    <= '0;
            r_move_time  <= '0;
            r_event_time <= '0;
        end else if (i_step) begin
            r_last_pos   <= n_last_pos;
            r_backlog    <= n_backlog;
            r_move_time  <= n_move_time;
            r_event_time <= n_event_time;
        end
    end

    // Delivering a button event drops the whole backlog.
    a_button_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_queued != EV_NONE) |=> r_backlog == '0)
        else $error("backlog survived a button event");

    // Any delivered event stamps the event time.
    a_event_stamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_code != EV_NONE) |=> r_event_time == $past(i_now))
        else $error("event time not updated on delivery");

    // Position is tracked on every processed word.
    a_pos_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |=> r_last_pos == $past(i_pos))
        else $error("last position not tracked");

endmodule

// ----- rtl/core/rotary_button_gesture_decoder.sv -----
// A poll word is captured in the input register and then moves into the result
// register. Throughput: one poll word per cycle while results are not stalled; the
// input register refills in the same cycle its word moves into the result register.
// The combinational path between them is the 32-bit backlog add and time compares.
// Reset (synchronous, active low) clears all gesture state to zero/idle, empties
// both registers and restores the configuration defaults; no clearing pass.
module rotary_button_gesture_decoder
    import rbg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Poll words in.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [71:0]           s_axis_tdata,  // now_ms[31:0], position[63:32],
                                                 // button_pressed[64], zero[71:65]
    // Result words out.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata   // event_code[2:0], zero[7:3]
);

    t_cfg               r_cfg;
    logic               r_in_vld;
    logic [TIME_W-1:0]  r_in_now;
    logic [POS_W-1:0]   r_in_pos;
    logic               r_in_pressed;
    logic               r_out_vld;
    t_event             r_out_code;

    logic               w_adv;
    t_event             w_queued;
    t_event             w_code;

    // Configuration registers; the user must write them only while the block is idle; the block does not enforce this.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.quiet_ms         <= DEBOUNCE_RST;
            r_cfg.hold_short_ms    <= HOLD_SHORT_RST;
            r_cfg.hold_long_ms     <= HOLD_LONG_RST;
            r_cfg.double_window_ms <= DBL_WINDOW_RST;
            r_cfg.stale_ms         <= STALE_RST;
            r_cfg.throttle_ms      <= THROTTLE_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DEBOUNCE:   r_cfg.quiet_ms         <= i_cfg_data;
                CFG_HOLD_SHORT: r_cfg.hold_short_ms    <= i_cfg_data;
                CFG_HOLD_LONG:  r_cfg.hold_long_ms     <= i_cfg_data;
                CFG_DBL_WINDOW: r_cfg.double_window_ms <= i_cfg_data;
                CFG_STALE:      r_cfg.stale_ms         <= i_cfg_data[7:0];
                CFG_THROTTLE:   r_cfg.throttle_ms      <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // A word moves from the input register to the result register when the
    // result register is empty or being drained.
    assign w_adv         = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_adv;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_now     <= s_axis_tdata[31:0];
            r_in_pos     <= s_axis_tdata[63:32];
            r_in_pressed <= s_axis_tdata[64];
        end
    end

    rbg_button u_button (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_adv),
        .i_now     (r_in_now),
        .i_pressed (r_in_pressed),
        .i_cfg     (r_cfg),
        .o_queued  (w_queued)
    );

    rbg_rotary u_rotary (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_adv),
        .i_now    (r_in_now),
        .i_pos    (r_in_pos),
        .i_queued (w_queued),
        .i_cfg    (r_cfg),
        .o_code   (w_code)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_code <= w_code;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {5'd0, r_out_code};

    // Results never carry an undefined code.
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> r_out_code <= EV_HOLD5)
        else $error("result code out of range");

    // A held input word blocks new words until it moves on.
    a_in_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !w_adv) |-> !s_axis_tready)
        else $error("input accepted over a stalled word");

    // A stalled result is not overwritten.
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !m_axis_tready) |-> !w_adv)
        else $error("result overwritten while stalled");

endmodule
